FILE: hw/rtl/sust_pkg.sv
// Shared types and constants for the sorted unique set table.
// Holds the capacity, data and count widths, request codes and the cell link struct.
// Depends on nothing; used by sust_cell, sorted_unique_set_table and the bench.
package sust_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int EXT_W    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_t;

  // What one cell hands to its right-hand neighbor.
  typedef struct packed {
    logic  less;
    data_t entry;
  } cell_link_t;

endpackage

FILE: hw/rtl/sust_cell.sv
// One storage cell of the sorted set chain: holds one entry and compares it.
// Depends on sust_pkg for the data type and the neighbor link struct.
module sust_cell (
  input  logic               clk,
  input  logic               shift_en,
  input  logic               occ,
  input  sust_pkg::data_t    value,
  input  sust_pkg::cell_link_t left,
  output sust_pkg::cell_link_t right,
  output logic               eq
);

  sust_pkg::data_t entry;
  logic            less;

  assign less        = occ && (entry < value);
  assign eq          = occ && (entry == value);
  assign right.less  = less;
  assign right.entry = entry;

  // Cells below the insert position keep their entry; the cell at the position
  // takes the new value and every cell after it takes its left neighbor's entry.
  always_ff @(posedge clk) begin
    if (shift_en && !less) begin
      entry <= left.less ? value : left.entry;
    end
  end

endmodule

FILE: hw/rtl/sorted_unique_set_table.sv
// Top level of the sorted unique set table: request register, cell chain, result register.
// Depends on sust_pkg and sust_cell.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------
//   request  | in_valid / in_ready  | req_type[1:0], value[31:0] signed
//   result   | out_valid / out_ready| found, stored, full_res, count[4:0]
//
// Each item is first captured in the request register; then all cells compare against
// it in parallel and the chain shifts on an insert. The single request register means
// the block takes no new request until the held one has passed the compare step.
// The result waits in its own register, so the next item is captured while it is held.
// Reset (rst, synchronous) empties the set and drops both valid flags; entries keep
// whatever they hold, since only cells below the count are ever compared.
// A stalled result blocks only the compare step; a captured request then waits.
module sorted_unique_set_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    req_type,
  input  logic signed [31:0]            value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          found,
  output logic                          stored,
  output logic                          full_res,
  output logic [sust_pkg::COUNT_W-1:0]  count
);

  // Captured request.
  logic            busy;
  sust_pkg::req_t  rq_type;
  sust_pkg::data_t rq_value;

  // Number of entries held; cells below it are occupied.
  logic [sust_pkg::CNT_W-1:0] cnt;
  logic [sust_pkg::CNT_W-1:0] cnt_next;
  logic [sust_pkg::EXT_W-1:0] cnt_ext;

  logic                       fire;
  logic                       hit;
  logic                       is_full;
  logic                       do_insert;
  logic                       refuse;
  logic [sust_pkg::CAPACITY-1:0] occ;
  logic [sust_pkg::CAPACITY-1:0] eq;
  sust_pkg::cell_link_t       link [sust_pkg::CAPACITY+1];

  assign in_ready = !busy;
  // The compare step runs once a request is held and the result register is free.
  assign fire     = busy && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_valid && in_ready) begin
      busy <= 1'b1;
    end else if (fire) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rq_type  <= sust_pkg::req_t'(req_type);
      rq_value <= value;
    end
  end

  // The head of the chain sees a neighbor that is always below the value, so the
  // first cell takes the new value when it is the insert position.
  assign link[0].less  = 1'b1;
  assign link[0].entry = rq_value;

  for (genvar i = 0; i < sust_pkg::CAPACITY; i++) begin : g_cell
    assign occ[i] = (cnt > sust_pkg::CNT_W'(i));
    sust_cell u_cell (
      .clk      (clk),
      .shift_en (do_insert),
      .occ      (occ[i]),
      .value    (rq_value),
      .left     (link[i]),
      .right    (link[i+1]),
      .eq       (eq[i])
    );
  end

  assign hit     = |eq;
  assign is_full = (cnt == sust_pkg::CNT_W'(sust_pkg::CAPACITY));

  always_comb begin
    do_insert = 1'b0;
    refuse    = 1'b0;
    cnt_next  = cnt;
    case (rq_type)
      sust_pkg::REQ_INSERT: begin
        if (!hit) begin
          if (is_full) begin
            refuse = fire;
          end else begin
            do_insert = fire;
            cnt_next  = cnt + sust_pkg::CNT_W'(1);
          end
        end
      end
      sust_pkg::REQ_CLEAR: begin
        cnt_next = '0;
      end
      default: begin
        // Lookups and the unused code leave the set unchanged.
        cnt_next = cnt;
      end
    endcase
  end

  assign cnt_ext = sust_pkg::EXT_W'(cnt_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (fire) begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      found    <= hit;
      stored   <= do_insert;
      full_res <= refuse;
      count    <= cnt_ext[sust_pkg::COUNT_W-1:0];
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= sust_pkg::CNT_W'(sust_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_stored_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && stored |-> !found && !full_res)
    else $error("stored result also flagged found or refused");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    fire && rq_type == sust_pkg::REQ_CLEAR |=> cnt == '0)
    else $error("clear left entries in the set");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    do_insert |=> cnt == $past(cnt) + sust_pkg::CNT_W'(1))
    else $error("insert did not grow the count by one");
`endif

endmodule

FILE: bench/sorted_unique_set_table_test.sv
// Self-checking bench for sorted_unique_set_table: drives requests, predicts every result.
// A shadow copy of the ordered set predicts each result; a scoreboard process checks them.
// Depends on sust_pkg and the sorted_unique_set_table RTL.
module sorted_unique_set_table_test;

  // Code 3 has no name in the package; the block treats it as a lookup.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam sust_pkg::data_t VAL_MIN = {1'b1, {(sust_pkg::DATA_W-1){1'b0}}};
  localparam sust_pkg::data_t VAL_MAX = {1'b0, {(sust_pkg::DATA_W-1){1'b1}}};
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic                         found;
    logic                         stored;
    logic                         full_res;
    logic [sust_pkg::COUNT_W-1:0] count;
  } set_result_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [1:0]                   req_type = sust_pkg::REQ_LOOKUP;
  sust_pkg::data_t              value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic                         found;
  logic                         stored;
  logic                         full_res;
  logic [sust_pkg::COUNT_W-1:0] count;

  // Shadow copy of the set, ascending, and the results still owed by the block.
  sust_pkg::data_t shadow_vals [sust_pkg::CAPACITY];
  int              shadow_size = 0;
  set_result_t     expected_results [$];

  int error_count = 0;
  int cycle_count = 0;
  bit idling = 1'b1;
  int idle_odds = 8;

  sorted_unique_set_table dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .found     (found),
    .stored    (stored),
    .full_res  (full_res),
    .count     (count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Applies one request to the shadow set and returns the result the block must give.
  // The search finds the first entry not below the value, in signed order.
  function automatic set_result_t apply_to_shadow_set(input logic [1:0] kind,
                                                      input sust_pkg::data_t val);
    set_result_t res;
    int pos;
    int j;
    res = '0;
    pos = 0;
    while (pos < shadow_size && shadow_vals[pos] < val) pos++;
    res.found = (pos < shadow_size) && (shadow_vals[pos] == val);
    if (kind == sust_pkg::REQ_INSERT && !res.found) begin
      if (shadow_size >= sust_pkg::CAPACITY) begin
        res.full_res = 1'b1;
      end else begin
        for (j = shadow_size; j > pos; j--) shadow_vals[j] = shadow_vals[j-1];
        shadow_vals[pos] = val;
        shadow_size++;
        res.stored = 1'b1;
      end
    end else if (kind == sust_pkg::REQ_CLEAR) begin
      shadow_size = 0;
    end
    res.count = shadow_size[sust_pkg::COUNT_W-1:0];
    return res;
  endfunction

  // Presents one item and holds it until accepted. Valid is left high so that a
  // following item goes out back to back; gaps lower it explicitly.
  task automatic send_item(input logic [1:0] kind, input sust_pkg::data_t val);
    in_valid <= 1'b1;
    req_type <= kind;
    value    <= val;
    do @(posedge clk); while (!in_ready);
    expected_results.insert(expected_results.size(), apply_to_shadow_set(kind, val));
  endtask

  // Random burst of sender idle cycles.
  task automatic sender_gap();
    if (idling && $urandom_range(1, idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Holds the sender off until the block has returned every result it owes.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Receiver side: random stall bursts while idling is on, otherwise always ready.
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (idling && $urandom_range(1, idle_odds) == 1) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Scoreboard: every accepted result is matched against the oldest prediction.
  always @(posedge clk) begin
    set_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: found=%0d stored=%0d full_res=%0d count=%0d",
               found, stored, full_res, count);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found);
          error_count++;
        end
        if (stored !== want.stored) begin
          $error("stored: expected %0d, got %0d", want.stored, stored);
          error_count++;
        end
        if (full_res !== want.full_res) begin
          $error("full_res: expected %0d, got %0d", want.full_res, full_res);
          error_count++;
        end
        if (count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, count);
          error_count++;
        end
      end
    end
  end

  // Extreme values, every request code, duplicates, and a clear of a present value.
  task automatic test_edge_values();
    send_item(sust_pkg::REQ_LOOKUP, VAL_MIN);
    send_item(sust_pkg::REQ_INSERT, VAL_MAX);
    send_item(sust_pkg::REQ_INSERT, VAL_MIN);
    send_item(sust_pkg::REQ_INSERT, '0);
    send_item(sust_pkg::REQ_INSERT, VAL_MIN);
    send_item(REQ_UNUSED, VAL_MAX);
    send_item(sust_pkg::REQ_CLEAR, '0);
  endtask

  // Fills the store in descending order so every insert shifts the whole chain,
  // then tries a new value and a present value while full, and empties it again.
  task automatic test_full_store();
    int i;
    for (i = sust_pkg::CAPACITY - 1; i >= 0; i--) begin
      send_item(sust_pkg::REQ_INSERT, sust_pkg::data_t'(i * 37 - 300));
    end
    send_item(sust_pkg::REQ_INSERT, sust_pkg::data_t'(5));
    send_item(sust_pkg::REQ_INSERT, sust_pkg::data_t'(-300));
    send_item(sust_pkg::REQ_CLEAR, sust_pkg::data_t'(-1));
  endtask

  // Rounds over a small pool of values so that duplicates, full sets and hits are
  // common; some values come from the whole 32-bit range.
  task automatic test_random_mix(input int rounds);
    sust_pkg::data_t pool [$];
    sust_pkg::data_t base;
    sust_pkg::data_t val;
    logic [1:0] kind;
    int r;
    int k;
    int pick;
    int len;
    for (r = 0; r < rounds; r++) begin
      pool.delete();
      base = $urandom;
      for (k = $urandom_range(3, sust_pkg::CAPACITY + 8); k > 0; k--) begin
        case ($urandom_range(0, 4))
          0, 1:    pool.insert(pool.size(), $urandom);
          2:       pool.insert(pool.size(), base + $urandom_range(0, 40));
          3:       pool.insert(pool.size(), $urandom_range(0, 1) ? VAL_MIN : VAL_MAX);
          default: pool.insert(pool.size(), sust_pkg::data_t'($urandom_range(0, 60)) - 30);
        endcase
      end
      idle_odds = $urandom_range(3, 30);
      len = $urandom_range(20, 60);
      for (k = 0; k < len; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 56)      kind = sust_pkg::REQ_INSERT;
        else if (pick < 90) kind = sust_pkg::REQ_LOOKUP;
        else if (pick < 97) kind = REQ_UNUSED;
        else                kind = sust_pkg::REQ_CLEAR;
        if ($urandom_range(0, 9) == 0) val = $urandom;
        else                           val = pool[$urandom_range(0, pool.size() - 1)];
        sender_gap();
        send_item(kind, val);
      end
      // Now and then the sender waits for the block to catch up completely.
      if (r % 7 == 3) drain_results();
    end
  endtask

  // Closing stretch with both sides always ready: one item after another.
  task automatic test_back_to_back();
    idling = 1'b0;
    test_random_mix(5);
  endtask

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : main_sequence
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_edge_values();
    test_full_store();
    test_random_mix(36);
    test_back_to_back();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/sust_pkg.sv
hw/rtl/sust_cell.sv
hw/rtl/sorted_unique_set_table.sv
bench/sorted_unique_set_table_test.sv
